@@ sv/lbs_pkg.sv @@
// Package for the linear blend skinning unit: payload structs, FSM states,
// controller/datapath command and status structs, sizing constants.
// No dependencies.
package lbs_pkg;

   localparam int MAX_BONES_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WEIGHT_BITS   = 16;
   localparam int ELEMS         = 12;

   typedef struct packed {
      logic               mode;
      logic [5:0]         bone_index;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic [16:0]        weight;
      logic               last_influence;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_norm_x;
      logic signed [31:0] out_norm_y;
      logic signed [31:0] out_norm_z;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_TAIL,
      ST_WEIGHT,
      ST_EMIT,
      ST_HOLD
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;      // capture input item
      logic       mem_write; // write matrix element
      logic       rd_issue;  // issue matrix read for row
      logic [1:0] row;       // row being read/multiplied (0..3)
      logic       mac;       // accumulate products of registered row
      logic       mac_trans; // registered row is translation
      logic       finish;    // shift/saturate both sums
      logic       wmul;      // weight multiply and accumulate
      logic       emit;      // load result register, clear accumulators
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic last;
      logic bone_ok;
   } status_type;

   // signed 64-bit saturating add
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return {1'b0, {63{1'b1}}};
      if (a[63] && b[63] && !s[63]) return {1'b1, {63{1'b0}}};
      return s;
   endfunction

   // saturate a 64-bit value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sh000000007FFFFFFF) return 32'sh7FFFFFFF;
      if (x < -64'sh0000000080000000) return 32'sh80000000;
      return x[31:0];
   endfunction

endpackage

@@ sv/linear_blend_skinning_unit.sv @@
// Linear blend skinning unit, top level.
// Channels: req_ (input item), rsp_ (blended vertex), valid/ready each.
// A mode 0 item writes one bone matrix element and is accepted every cycle
// while the controller is idle. A mode 1 item passes from the accept state
// through the row states, which read the bone's rows from the column-banked
// store one row a cycle while the previous row is multiplied on six 32x32
// multipliers, then a state that adds translation, one that shifts and
// saturates and one that weights and accumulates, before the next accept.
// An influence marked last then waits in a hold state that moves the sums
// into the output register, which drives rsp_valid.
// While the receiver stalls the result waits in the output register and
// input goes on; a further last influence holds in the controller, with
// no item accepted, until the register frees. Sums clear on that move.
// Synchronous reset clears the controller, the output register's valid
// and the accumulators; the bone store holds no defined value until written.
// Depends on lbs_pkg, lbs_ctrl, lbs_datapath.
module linear_blend_skinning_unit #(
   parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
   parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lbs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lbs_pkg::rsp_type rsp_data
);

   lbs_pkg::cmd_type    cmd;
   lbs_pkg::status_type status;

   lbs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   lbs_datapath #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .req_data, .cmd, .status, .rsp_data
   );

endmodule

@@ sv/lbs_ctrl.sv @@
// Controller FSM of the linear blend skinning unit.
// Depends on lbs_pkg.
module lbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lbs_pkg::status_type status,
   output lbs_pkg::cmd_type    cmd
);

   lbs_pkg::state_type state_ff, state_in;
   logic [1:0] row_ff, row_in;
   logic       rsp_full_ff, rsp_full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lbs_pkg::ST_IDLE;
         row_ff      <= 2'd0;
         rsp_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   assign rsp_valid = rsp_full_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.mode) begin
                  state_in = lbs_pkg::ST_ROW;
                  row_in   = 2'd0;
               end
            end
         end
         // issue read of row_ff, multiply row registered last cycle
         lbs_pkg::ST_ROW: begin
            cmd.rd_issue  = 1'b1;
            cmd.row       = row_ff;
            cmd.mac       = (row_ff != 2'd0);
            cmd.mac_trans = 1'b0;
            row_in        = row_ff + 2'd1;
            if (row_ff == 2'd3) state_in = lbs_pkg::ST_TAIL;
         end
         lbs_pkg::ST_TAIL: begin
            cmd.mac       = 1'b1;
            cmd.mac_trans = 1'b1;
            state_in      = lbs_pkg::ST_WEIGHT;
         end
         lbs_pkg::ST_WEIGHT: begin
            cmd.finish = 1'b1;
            state_in   = lbs_pkg::ST_EMIT;
         end
         lbs_pkg::ST_EMIT: begin
            cmd.wmul = status.bone_ok;
            state_in = status.last ? lbs_pkg::ST_HOLD : lbs_pkg::ST_IDLE;
         end
         // move the sums to the output register once it frees up
         lbs_pkg::ST_HOLD: begin
            if (!rsp_full_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = lbs_pkg::ST_IDLE;
            end
         end
         default: state_in = lbs_pkg::ST_IDLE;
      endcase
      if (state_ff == lbs_pkg::ST_IDLE && req_valid && !status.mode)
         cmd.mem_write = 1'b1;
      // output register fills on emit, drains when taken
      rsp_full_in = cmd.emit || (rsp_full_ff && !rsp_ready);
   end

   // hold a stalled result, never accept while busy, tail only after the last row, emit only into a free register
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != lbs_pkg::ST_IDLE |-> !req_ready)
      else $error("accept while busy");
   a_tail_after_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == lbs_pkg::ST_TAIL |-> $past(state_ff) == lbs_pkg::ST_ROW)
      else $error("tail not after last row");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_full_ff || rsp_ready)
      else $error("result overwritten");

endmodule

@@ sv/lbs_datapath.sv @@
// Datapath of the linear blend skinning unit: bone store, row MAC,
// weighting and the six saturating accumulators. Depends on lbs_pkg.
module lbs_datapath #(
   parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
   parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lbs_pkg::req_type    req_data,
   input  lbs_pkg::cmd_type    cmd,
   output lbs_pkg::status_type status,
   output lbs_pkg::rsp_type    rsp_data
);

   localparam int BW    = 6;

   // three column-wide memory banks, one row of the matrix per read
   logic signed [31:0] mem0 [MAX_BONES*4];
   logic signed [31:0] mem1 [MAX_BONES*4];
   logic signed [31:0] mem2 [MAX_BONES*4];
   localparam int RAW = (MAX_BONES*4 > 1) ? $clog2(MAX_BONES*4) : 1;

   lbs_pkg::req_type   item_ff;
   logic signed [31:0] rd_ff [3];
   logic signed [63:0] spos_ff [3];
   logic signed [63:0] snrm_ff [3];
   logic signed [31:0] tpos_ff [3];
   logic signed [31:0] tnrm_ff [3];
   logic signed [63:0] acc_ff [6];
   lbs_pkg::rsp_type   rsp_ff;

   logic [BW+5:0] waddr_full;
   logic [RAW-1:0] waddr, raddr;
   logic [1:0] wrow;
   logic [1:0] wcol;
   logic bone_in_range;

   // row and column of the element
   always_comb begin
      wrow = 2'd0;
      wcol = 2'd0;
      if (req_data.element_index >= 4'd9) begin
         wrow = 2'd3; wcol = 2'(req_data.element_index - 4'd9);
      end else if (req_data.element_index >= 4'd6) begin
         wrow = 2'd2; wcol = 2'(req_data.element_index - 4'd6);
      end else if (req_data.element_index >= 4'd3) begin
         wrow = 2'd1; wcol = 2'(req_data.element_index - 4'd3);
      end else begin
         wcol = 2'(req_data.element_index);
      end
      waddr_full = {4'd0, req_data.bone_index, wrow};
      waddr = RAW'(waddr_full);
      raddr = RAW'({4'd0, item_ff.bone_index, cmd.row});
   end

   assign bone_in_range = 32'(req_data.bone_index) < MAX_BONES;

   // write and read the bone store
   always_ff @(posedge clock) begin
      if (cmd.mem_write && bone_in_range && req_data.element_index < 4'(lbs_pkg::ELEMS)) begin
         case (wcol)
            2'd0: mem0[waddr] <= req_data.element_value;
            2'd1: mem1[waddr] <= req_data.element_value;
            default: mem2[waddr] <= req_data.element_value;
         endcase
      end
      if (cmd.rd_issue) begin
         rd_ff[0] <= mem0[raddr];
         rd_ff[1] <= mem1[raddr];
         rd_ff[2] <= mem2[raddr];
      end
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
   end

   // row element of each input vector for the registered row (row = cmd.row-1)
   logic [1:0] mrow;
   logic signed [31:0] pv, nv;
   assign mrow = cmd.row - 2'd1;
   always_comb begin
      case (mrow)
         2'd0: begin pv = item_ff.pos_x; nv = item_ff.norm_x; end
         2'd1: begin pv = item_ff.pos_y; nv = item_ff.norm_y; end
         default: begin pv = item_ff.pos_z; nv = item_ff.norm_z; end
      endcase
   end

   // multiply-accumulate one row on six 32x32 multipliers, or add translation; clear on load
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.load) begin
            spos_ff[c] <= '0;
            snrm_ff[c] <= '0;
         end else if (cmd.mac && cmd.mac_trans) begin
            spos_ff[c] <= lbs_pkg::sat_add64(spos_ff[c],
                          64'(signed'(rd_ff[c])) <<< FRAC_BITS);
         end else if (cmd.mac) begin
            spos_ff[c] <= lbs_pkg::sat_add64(spos_ff[c],
                          64'(signed'(pv)) * 64'(signed'(rd_ff[c])));
            snrm_ff[c] <= lbs_pkg::sat_add64(snrm_ff[c],
                          64'(signed'(nv)) * 64'(signed'(rd_ff[c])));
         end
      end
   end

   // floor shift and saturate
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         for (int c = 0; c < 3; c++) begin
            tpos_ff[c] <= lbs_pkg::sat32(spos_ff[c] >>> FRAC_BITS);
            tnrm_ff[c] <= lbs_pkg::sat32(snrm_ff[c] >>> FRAC_BITS);
         end
      end
   end

   // weight and accumulate, clear on reset or emit
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         for (int i = 0; i < 6; i++) acc_ff[i] <= '0;
      end else if (cmd.wmul) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= lbs_pkg::sat_add64(acc_ff[c],
                         64'(signed'(tpos_ff[c])) * 64'(signed'({1'b0, item_ff.weight})));
            acc_ff[3+c] <= lbs_pkg::sat_add64(acc_ff[3+c],
                           64'(signed'(tnrm_ff[c])) * 64'(signed'({1'b0, item_ff.weight})));
         end
      end
   end

   // move the finished vertex into the output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.out_pos_x  <= lbs_pkg::sat32(acc_ff[0] >>> lbs_pkg::WEIGHT_BITS);
         rsp_ff.out_pos_y  <= lbs_pkg::sat32(acc_ff[1] >>> lbs_pkg::WEIGHT_BITS);
         rsp_ff.out_pos_z  <= lbs_pkg::sat32(acc_ff[2] >>> lbs_pkg::WEIGHT_BITS);
         rsp_ff.out_norm_x <= lbs_pkg::sat32(acc_ff[3] >>> lbs_pkg::WEIGHT_BITS);
         rsp_ff.out_norm_y <= lbs_pkg::sat32(acc_ff[4] >>> lbs_pkg::WEIGHT_BITS);
         rsp_ff.out_norm_z <= lbs_pkg::sat32(acc_ff[5] >>> lbs_pkg::WEIGHT_BITS);
      end
   end

   assign status.mode    = req_data.mode;
   assign status.last    = item_ff.last_influence;
   assign status.bone_ok = 32'(item_ff.bone_index) < MAX_BONES;

   assign rsp_data = rsp_ff;

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> acc_ff[0] == 64'sd0 && acc_ff[5] == 64'sd0)
      else $error("sums not cleared");
   a_no_mix: assert property (@(posedge clock) disable iff (reset)
      cmd.wmul |-> !cmd.mac && !cmd.emit)
      else $error("overlapping commands");
   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> spos_ff[0] == 64'sd0)
      else $error("row sum not cleared");

endmodule

@@ test/testbench.sv @@
// Testbench for the linear blend skinning unit: directed and random bone
// writes and vertex influences, checked against an in-bench skinning predictor.
// Depends on lbs_pkg and linear_blend_skinning_unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BONES = 64;
   localparam int NUM_LOADED = 16;
   localparam int RANDOM_PHASE = 190;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_INFLUENCE = 1'b1;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   lbs_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   lbs_pkg::rsp_type rsp_data;

   linear_blend_skinning_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // predictor state
   logic signed [31:0] bone_store [NUM_BONES*12];
   bit                 bone_written [NUM_BONES*12];
   logic signed [63:0] blend_sums [6];
   lbs_pkg::rsp_type   vertex_queue [$];

   int  error_count;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_off_cycles;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return {1'b0, {63{1'b1}}};
      if (a[63] && b[63] && !s[63]) return {1'b1, {63{1'b0}}};
      return s;
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // one column of v*M, translation optional
   function automatic logic signed [31:0] column_xform(int base, int c,
         logic signed [31:0] v0, logic signed [31:0] v1, logic signed [31:0] v2,
         bit add_trans);
      logic signed [63:0] s;
      logic signed [63:0] t;
      s = 64'sd0;
      s = sat_sum(s, 64'(v0) * 64'(bone_store[base + c]));
      s = sat_sum(s, 64'(v1) * 64'(bone_store[base + 3 + c]));
      s = sat_sum(s, 64'(v2) * 64'(bone_store[base + 6 + c]));
      if (add_trans) begin
         t = 64'(bone_store[base + 9 + c]);
         s = sat_sum(s, t <<< 16);
      end
      return clamp32(s >>> 16);
   endfunction

   // apply one item to the predictor
   task automatic skin_predict(lbs_pkg::req_type it);
      int base;
      logic signed [63:0] w;
      logic signed [31:0] p [3];
      logic signed [31:0] n [3];
      lbs_pkg::rsp_type r;
      if (it.mode == MODE_WRITE) begin
         if (it.element_index < 12) begin
            bone_store[it.bone_index*12 + it.element_index] = it.element_value;
            bone_written[it.bone_index*12 + it.element_index] = 1'b1;
         end
         return;
      end
      base = it.bone_index * 12;
      w = 64'(it.weight);
      for (int c = 0; c < 3; c++) begin
         p[c] = column_xform(base, c, it.pos_x, it.pos_y, it.pos_z, 1'b1);
         n[c] = column_xform(base, c, it.norm_x, it.norm_y, it.norm_z, 1'b0);
         blend_sums[c] = sat_sum(blend_sums[c], 64'(p[c]) * w);
         blend_sums[3+c] = sat_sum(blend_sums[3+c], 64'(n[c]) * w);
      end
      if (it.last_influence) begin
         r.out_pos_x  = clamp32(blend_sums[0] >>> 16);
         r.out_pos_y  = clamp32(blend_sums[1] >>> 16);
         r.out_pos_z  = clamp32(blend_sums[2] >>> 16);
         r.out_norm_x = clamp32(blend_sums[3] >>> 16);
         r.out_norm_y = clamp32(blend_sums[4] >>> 16);
         r.out_norm_z = clamp32(blend_sums[5] >>> 16);
         vertex_queue = {vertex_queue, r};
         for (int c = 0; c < 6; c++) blend_sums[c] = 64'sd0;
      end
   endtask

   // send one item, idling at random first; valid stays up after accept
   // until the next item, an idle cycle or a drain replaces it
   task automatic send_item(lbs_pkg::req_type it);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      skin_predict(it);
   endtask

   task automatic write_element(int bone, int elem, logic signed [31:0] val);
      lbs_pkg::req_type it;
      it = '0;
      it.mode = MODE_WRITE;
      it.bone_index = 6'(bone);
      it.element_index = 4'(elem);
      it.element_value = val;
      it.last_influence = 1'($urandom_range(1));
      send_item(it);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'($signed($urandom));
         default: return 32'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
      endcase
   endfunction

   // true once every element of the bone has been written
   function automatic bit bone_loaded(int b);
      for (int e = 0; e < 12; e++)
         if (!bone_written[b*12 + e]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int pick_bone();
      int b;
      b = $urandom_range(NUM_BONES - 1);
      while (!bone_loaded(b)) b = $urandom_range(NUM_BONES - 1);
      return b;
   endfunction

   task automatic send_influence(int bone, logic [16:0] w, bit last_mark);
      lbs_pkg::req_type it;
      it.mode = MODE_INFLUENCE;
      it.bone_index = 6'(bone);
      it.element_index = 4'($urandom_range(15));
      it.element_value = $urandom;
      it.pos_x = rand_coord();
      it.pos_y = rand_coord();
      it.pos_z = rand_coord();
      it.norm_x = rand_coord();
      it.norm_y = rand_coord();
      it.norm_z = rand_coord();
      it.weight = w;
      it.last_influence = last_mark;
      send_item(it);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (vertex_queue.size() > 0) @(posedge clock);
   endtask

   // load the first bones, extremes on a few
   task automatic test_load_bones();
      for (int b = 0; b < NUM_LOADED; b++)
         for (int e = 0; e < 12; e++) begin
            if (b == 1) write_element(b, e, (e % 4 == 0) ? 32'sh00010000 : 32'sh0);
            else if (b == 2) write_element(b, e, 32'sh7FFFFFFF);
            else if (b == 3) write_element(b, e, 32'sh80000000);
            else write_element(b, e, rand_coord());
         end
   endtask

   // extremes, bad element index, zero and large weights, lone last
   task automatic test_directed();
      write_element(5, 12 + $urandom_range(3), 32'sh12345678);
      send_influence(1, 17'd65536, 1'b1);
      send_influence(2, 17'h1FFFF, 1'b0);
      send_influence(2, 17'h1FFFF, 1'b0);
      send_influence(3, 17'h1FFFF, 1'b1);
      send_influence(3, 17'd0, 1'b1);
      send_influence(4, 17'd32768, 1'b0);
      send_influence(6, 17'd32768, 1'b1);
      for (int k = 0; k < 6; k++) send_influence(2, 17'h1FFFF, k == 5);
      send_influence(0, 17'd65535, 1'b1);
      drain_results();
   endtask

   // mostly well-formed vertices, some stray writes and odd weights
   task automatic test_random(int count);
      int sent;
      int n;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            write_element($urandom_range(NUM_BONES - 1), $urandom_range(11), rand_coord());
            sent++;
         end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
               send_influence(pick_bone(),
                  ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536)),
                  k == n - 1);
               sent++;
            end
         end
      end
   endtask

   // receiver holds off while the sender keeps going
   task automatic test_backpressure();
      hold_off_cycles = 300;
      test_random(20);
      drain_results();
      // sender pauses until all results are in
      test_random(10);
      drain_results();
   endtask

   // receiver: random stalls and long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // check each taken result
   always @(posedge clock) begin
      lbs_pkg::rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (vertex_queue.size() == 0) begin
            $error("result with nothing expected");
            error_count++;
         end else begin
            exp = vertex_queue.pop_front();
            if (rsp_data.out_pos_x !== exp.out_pos_x) begin
               $error("out_pos_x exp %0d got %0d", exp.out_pos_x, rsp_data.out_pos_x);
               error_count++;
            end
            if (rsp_data.out_pos_y !== exp.out_pos_y) begin
               $error("out_pos_y exp %0d got %0d", exp.out_pos_y, rsp_data.out_pos_y);
               error_count++;
            end
            if (rsp_data.out_pos_z !== exp.out_pos_z) begin
               $error("out_pos_z exp %0d got %0d", exp.out_pos_z, rsp_data.out_pos_z);
               error_count++;
            end
            if (rsp_data.out_norm_x !== exp.out_norm_x) begin
               $error("out_norm_x exp %0d got %0d", exp.out_norm_x, rsp_data.out_norm_x);
               error_count++;
            end
            if (rsp_data.out_norm_y !== exp.out_norm_y) begin
               $error("out_norm_y exp %0d got %0d", exp.out_norm_y, rsp_data.out_norm_y);
               error_count++;
            end
            if (rsp_data.out_norm_z !== exp.out_norm_z) begin
               $error("out_norm_z exp %0d got %0d", exp.out_norm_z, rsp_data.out_norm_z);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      quiet_cycles = 0;
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      for (int i = 0; i < NUM_BONES*12; i++) begin
         bone_store[i] = '0;
         bone_written[i] = 1'b0;
      end
      for (int c = 0; c < 6; c++) blend_sums[c] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_load_bones();
      test_directed();
      test_backpressure();
      test_random(RANDOM_PHASE);
      drain_results();
      send_idle_pct = 51;
      test_random(RANDOM_PHASE);
      drain_results();
      send_idle_pct = 0;
      recv_stall_pct = 51;
      test_random(RANDOM_PHASE);
      drain_results();
      send_idle_pct = 32;
      recv_stall_pct = 32;
      test_random(RANDOM_PHASE);
      drain_results();
      repeat (20) @(posedge clock);

      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
